/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the frame header CRC checker.
// Stands alone; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/fhcc_pkg.sv */
// Types and constants of the frame header CRC checker.
// Used by every module of the block except fhcc_crc8, and by its checker; depends on nothing.
package fhcc_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int CRC_BYTES    = 4;
	localparam logic [15:0] MIN_FRAME = 16'(HEADER_BYTES + CRC_BYTES);
	localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

	localparam logic [31:0] POLY_RESET    = 32'hEDB8_8320;
	localparam logic [15:0] MAGIC_RESET   = 16'hABCD;
	localparam logic [7:0]  VERSION_RESET = 8'h01;
	localparam logic [15:0] LENGTH_RESET  = 16'd404;

	localparam logic [1:0] CFG_POLY    = 2'd0;
	localparam logic [1:0] CFG_MAGIC   = 2'd1;
	localparam logic [1:0] CFG_VERSION = 2'd2;
	localparam logic [1:0] CFG_LENGTH  = 2'd3;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_MAGIC   = 3'd1,
		ERR_VERSION = 3'd2,
		ERR_SEQ     = 3'd3,
		ERR_LENGTH  = 3'd4,
		ERR_CRC     = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] expected_seq;
	} byte_word_t;

	typedef struct packed {
		logic        frame_ok;
		err_t        error_code;
		logic [31:0] computed_crc;
		logic [15:0] received_seq;
	} verdict_t;

	typedef struct packed {
		logic [31:0] poly;
		logic [15:0] magic;
		logic [7:0]  version;
		logic [15:0] length;
	} cfg_t;

endpackage

/* rtl/fhcc_cfg.sv */
// Configuration registers of the frame header CRC checker.
// Depends on fhcc_pkg for the register indexes, reset values and cfg_t.
module fhcc_cfg import fhcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly    <= POLY_RESET;
			cfg_q.magic   <= MAGIC_RESET;
			cfg_q.version <= VERSION_RESET;
			cfg_q.length  <= LENGTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLY:    cfg_q.poly    <= cfg_data;
				CFG_MAGIC:   cfg_q.magic   <= cfg_data[15:0];
				CFG_VERSION: cfg_q.version <= cfg_data[7:0];
				CFG_LENGTH:  cfg_q.length  <= cfg_data[15:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/fhcc_crc8.sv */
// One-byte update of a reflected CRC-32 with a programmable polynomial.
// Pure combinational logic; depends on nothing.
module fhcc_crc8 (
	input  logic [31:0] crc_in,
	input  logic [31:0] poly,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);

	logic [31:0] c;

	always_comb begin
		c = crc_in ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

/* rtl/fhcc_track.sv */
// Frame tracker: byte position, running CRC, header fields, trailer and verdict.
// Depends on fhcc_pkg and instantiates fhcc_crc8.
module fhcc_track import fhcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       accept,
	input  byte_word_t word,
	output logic       last_pos,
	output verdict_t   verdict
);

	localparam logic [15:0] POS_MAGIC0  = 16'd0;
	localparam logic [15:0] POS_MAGIC1  = 16'd1;
	localparam logic [15:0] POS_VERSION = 16'd2;
	localparam logic [15:0] POS_SEQ0    = 16'd4;
	localparam logic [15:0] POS_SEQ1    = 16'd5;
	localparam logic [15:0] POS_TLEN0   = 16'd10;
	localparam logic [15:0] POS_TLEN1   = 16'd11;
	localparam logic [15:0] POS_TLEN2   = 16'd12;
	localparam logic [15:0] POS_TLEN3   = 16'd13;

	logic [15:0] pos_q, magic_q, seq_q, tlo_q, seql_q;
	logic [7:0]  ver_q;
	logic        thi_q;
	logic [31:0] crc_q, trailer_q;

	logic [15:0] magic_n, seq_n, tlo_n, seql_n, eff;
	logic [7:0]  ver_n;
	logic        thi_n, first, covered;
	logic [31:0] crc_base, crc_upd, crc_n, trailer_n, crc_fin;
	err_t        err;

	fhcc_crc8 u_crc8 (
		.crc_in  (crc_base),
		.poly    (cfg.poly),
		.data    (word.data_byte),
		.crc_out (crc_upd)
	);

	always_comb begin
		eff      = (cfg.length < MIN_FRAME) ? MIN_FRAME : cfg.length;
		first    = (pos_q == 16'd0);
		covered  = (pos_q < (eff - 16'(CRC_BYTES)));
		last_pos = (pos_q >= (eff - 16'd1));
		crc_base = first ? CRC_INIT : crc_q;
		seql_n   = first ? word.expected_seq : seql_q;
		crc_n    = covered ? crc_upd : crc_base;
		trailer_n = covered ? trailer_q : {word.data_byte, trailer_q[31:8]};
		crc_fin  = ~crc_n;
	end

	always_comb begin
		magic_n = magic_q;
		ver_n   = ver_q;
		seq_n   = seq_q;
		tlo_n   = tlo_q;
		thi_n   = thi_q;
		case (pos_q) inside
			POS_MAGIC0:  magic_n[7:0]  = word.data_byte;
			POS_MAGIC1:  magic_n[15:8] = word.data_byte;
			POS_VERSION: ver_n         = word.data_byte;
			POS_SEQ0:    seq_n[7:0]    = word.data_byte;
			POS_SEQ1:    seq_n[15:8]   = word.data_byte;
			POS_TLEN0:   tlo_n[7:0]    = word.data_byte;
			POS_TLEN1: begin
				tlo_n[15:8] = word.data_byte;
				thi_n       = 1'b0;
			end
			POS_TLEN2, POS_TLEN3: begin
				if (word.data_byte != 8'd0) begin
					thi_n = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Checks are prioritized; the first failing one is reported.
	always_comb begin
		if (magic_n != cfg.magic) begin
			err = ERR_MAGIC;
		end else if (ver_n != cfg.version) begin
			err = ERR_VERSION;
		end else if (seq_n != seql_n) begin
			err = ERR_SEQ;
		end else if (thi_n || (tlo_n != cfg.length)) begin
			err = ERR_LENGTH;
		end else if (crc_fin != trailer_n) begin
			err = ERR_CRC;
		end else begin
			err = ERR_NONE;
		end
		verdict.frame_ok     = (err == ERR_NONE);
		verdict.error_code   = err;
		verdict.computed_crc = crc_fin;
		verdict.received_seq = seq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 16'd0;
			crc_q     <= CRC_INIT;
			magic_q   <= 16'd0;
			ver_q     <= 8'd0;
			seq_q     <= 16'd0;
			tlo_q     <= 16'd0;
			thi_q     <= 1'b0;
			seql_q    <= 16'd0;
			trailer_q <= 32'd0;
		end else if (accept) begin
			pos_q     <= last_pos ? 16'd0 : (pos_q + 16'd1);
			crc_q     <= crc_n;
			magic_q   <= magic_n;
			ver_q     <= ver_n;
			seq_q     <= seq_n;
			tlo_q     <= tlo_n;
			thi_q     <= thi_n;
			seql_q    <= seql_n;
			trailer_q <= trailer_n;
		end
	end

endmodule

/* rtl/fhcc_out.sv */
// Result register of the frame header CRC checker: holds one verdict word.
// Depends on fhcc_pkg for verdict_t.
module fhcc_out import fhcc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  verdict_t verdict,
	input  logic     stall,
	output logic     valid,
	output verdict_t word
);

	logic     valid_q;
	verdict_t word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= verdict;
		end
	end

	assign valid = valid_q;
	assign word  = word_q;

endmodule

/* rtl/frame_header_crc_checker.sv */
// Top level of the frame header CRC checker.
// Depends on fhcc_pkg; instantiates fhcc_cfg, fhcc_track and fhcc_out.
//
// Frame bytes enter on the frame channel, one word per byte, with the expected
// sequence number sampled along with the first byte of each frame. After the
// last byte of a frame (configured length, at least 20 bytes) one verdict word
// leaves on the verdict channel; no other byte produces a word.
// Every byte is handled in the cycle it is accepted, so the block takes one
// byte per clock cycle while frame_stall is low. The verdict is valid in the
// cycle after its last byte is accepted. The one-byte CRC update and the header
// checks sit between the tracker registers and the verdict register.
// While a verdict waits under stall, bytes keep being accepted; only the last
// byte of the next frame is held off until the waiting verdict is taken.
// Reset restores the register defaults and starts at the first frame byte.
// Configuration writes take effect at the next edge and are meant for idle.
module frame_header_crc_checker import fhcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  byte_word_t  frame_word,
	output logic        verdict_valid,
	input  logic        verdict_stall,
	output verdict_t    verdict_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t     cfg;
	logic     accept, last_pos;
	verdict_t verdict;

	fhcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fhcc_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.word     (frame_word),
		.last_pos (last_pos),
		.verdict  (verdict)
	);

	fhcc_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept && last_pos),
		.verdict (verdict),
		.stall   (verdict_stall),
		.valid   (verdict_valid),
		.word    (verdict_word)
	);

	assign frame_stall = verdict_valid && verdict_stall && last_pos;
	assign accept      = frame_valid && !frame_stall;

endmodule

/* rtl/fhcc_checker.sv */
// Port-level checks of the frame header CRC checker, bound to its top level.
// Depends on fhcc_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module fhcc_checker import fhcc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_stall,
	input logic        verdict_valid,
	input logic        verdict_stall,
	input verdict_t    verdict_word
);

	logic in_take, out_hold, out_take_idle, ok_consistent;

	assign in_take       = frame_valid && !frame_stall;
	assign out_hold      = verdict_valid && verdict_stall;
	assign out_take_idle = verdict_valid && !verdict_stall && !in_take;
	assign ok_consistent = verdict_word.frame_ok == (verdict_word.error_code == ERR_NONE);

	`ASSERT_NEXT(a_verdict_held, clk, arst_n, out_hold, verdict_valid && $stable(verdict_word))
	`ASSERT_IMPLIES(a_ok_matches_code, clk, arst_n, verdict_valid, ok_consistent)
	`ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, frame_stall, out_hold)
	`ASSERT_NEXT(a_no_spurious_verdict, clk, arst_n, out_take_idle, !verdict_valid)

endmodule

bind frame_header_crc_checker fhcc_checker u_fhcc_checker (.*);

/* tb/tb.sv */
// Testbench for frame_header_crc_checker. It streams whole frames one byte word at a time.
// Each verdict is checked against a predictor of the checker that this file keeps.
// Depends on fhcc_pkg and the RTL of the block, and reads no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fhcc_pkg::*;

	localparam int RANDOM_BYTES = 450;
	localparam int SETTLE_CYCLES = 4;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef enum int {
		FLAW_NONE,
		FLAW_MAGIC,
		FLAW_VERSION,
		FLAW_SEQ,
		FLAW_LEN_LOW,
		FLAW_LEN_HIGH,
		FLAW_CRC,
		FLAW_MANY,
		FLAW_NOISE
	} flaw_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic frame_valid = 1'b0;
	logic frame_stall;
	byte_word_t frame_word = '0;
	logic verdict_valid;
	logic verdict_stall = 1'b0;
	verdict_t verdict_word;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_POLY;
	logic [31:0] cfg_data = '0;

	logic [31:0] poly_q = POLY_RESET;
	logic [15:0] magic_q = MAGIC_RESET;
	logic [7:0] version_q = VERSION_RESET;
	logic [15:0] length_q = LENGTH_RESET;

	logic [15:0] at_pos = '0;
	logic [31:0] crc_acc = CRC_INIT;
	logic [15:0] hdr_magic = '0;
	logic [7:0] hdr_version = '0;
	logic [15:0] hdr_seq = '0;
	logic [15:0] hdr_total_lo = '0;
	logic hdr_total_hi = 1'b0;
	logic [15:0] seq_sampled = '0;
	logic [31:0] trailer = '0;

	verdict_t verdicts_due[$];
	verdict_t oldest_due;
	logic [7:0] frame_bytes[$];
	int mismatches = 0;
	int words_sent = 0;
	int stall_hold = 0;
	bit calm = 1'b0;
	longint cycles = 0;

	frame_header_crc_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame_word(frame_word),
		.verdict_valid(verdict_valid),
		.verdict_stall(verdict_stall),
		.verdict_word(verdict_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ poly_q) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [15:0] frame_span();
		return (length_q < MIN_FRAME) ? MIN_FRAME : length_q;
	endfunction

	function automatic void absorb_byte(input byte_word_t w);
		logic [15:0] span_len;
		logic [7:0] b;
		verdict_t v;
		span_len = frame_span();
		b = w.data_byte;
		if (at_pos == 16'd0) begin
			crc_acc = CRC_INIT;
			seq_sampled = w.expected_seq;
		end
		case (at_pos)
			16'd0: hdr_magic[7:0] = b;
			16'd1: hdr_magic[15:8] = b;
			16'd2: hdr_version = b;
			16'd4: hdr_seq[7:0] = b;
			16'd5: hdr_seq[15:8] = b;
			16'd10: hdr_total_lo[7:0] = b;
			16'd11: begin
				hdr_total_lo[15:8] = b;
				hdr_total_hi = 1'b0;
			end
			16'd12, 16'd13: begin
				if (b != 8'd0) begin
					hdr_total_hi = 1'b1;
				end
			end
			default: ;
		endcase
		if (at_pos < span_len - CRC_BYTES) begin
			crc_acc = crc_step(crc_acc, b);
		end else begin
			trailer = {b, trailer[31:8]};
		end
		if (at_pos < span_len - 1) begin
			at_pos = at_pos + 16'd1;
		end else begin
			at_pos = '0;
			v.computed_crc = ~crc_acc;
			v.received_seq = hdr_seq;
			if (hdr_magic != magic_q) begin
				v.error_code = ERR_MAGIC;
			end else if (hdr_version != version_q) begin
				v.error_code = ERR_VERSION;
			end else if (hdr_seq != seq_sampled) begin
				v.error_code = ERR_SEQ;
			end else if (hdr_total_hi || hdr_total_lo != length_q) begin
				v.error_code = ERR_LENGTH;
			end else if (~crc_acc != trailer) begin
				v.error_code = ERR_CRC;
			end else begin
				v.error_code = ERR_NONE;
			end
			v.frame_ok = (v.error_code == ERR_NONE);
			verdicts_due.push_back(v);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && verdict_valid && !verdict_stall) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: verdict %h arrived with none expected", $time, verdict_word);
				mismatches++;
			end else begin
				oldest_due = verdicts_due.pop_front();
				if (verdict_word.frame_ok !== oldest_due.frame_ok) begin
					$display("%0t: frame_ok expected %0d got %0d", $time,
						oldest_due.frame_ok, verdict_word.frame_ok);
					mismatches++;
				end
				if (verdict_word.error_code !== oldest_due.error_code) begin
					$display("%0t: error_code expected %0d got %0d", $time,
						oldest_due.error_code, verdict_word.error_code);
					mismatches++;
				end
				if (verdict_word.computed_crc !== oldest_due.computed_crc) begin
					$display("%0t: computed_crc expected %h got %h", $time,
						oldest_due.computed_crc, verdict_word.computed_crc);
					mismatches++;
				end
				if (verdict_word.received_seq !== oldest_due.received_seq) begin
					$display("%0t: received_seq expected %h got %h", $time,
						oldest_due.received_seq, verdict_word.received_seq);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (calm || $urandom_range(0, 3) != 0) begin
			verdict_stall <= 1'b0;
			stall_hold <= calm ? 0 : $urandom_range(0, 6);
		end else begin
			verdict_stall <= 1'b1;
			stall_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_byte(input byte_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_valid <= 1'b1;
		frame_word <= w;
		@(posedge clk);
		while (frame_stall) @(posedge clk);
		absorb_byte(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		frame_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_POLY: poly_q = value;
			CFG_MAGIC: magic_q = value[15:0];
			CFG_VERSION: version_q = value[7:0];
			CFG_LENGTH: length_q = value[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic void spoil_header(input flaw_e f);
		logic [7:0] flip;
		int k;
		flip = 8'($urandom_range(1, 255));
		case (f)
			FLAW_MAGIC: k = $urandom_range(0, 1);
			FLAW_VERSION: k = 2;
			FLAW_SEQ: k = $urandom_range(4, 5);
			FLAW_LEN_LOW: k = $urandom_range(10, 11);
			FLAW_LEN_HIGH: k = $urandom_range(12, 13);
			default: k = -1;
		endcase
		if (k >= 0) begin
			frame_bytes[k] = frame_bytes[k] ^ flip;
		end
	endfunction

	task automatic build_frame(input logic [15:0] seq, input flaw_e flaw, input int fill);
		logic [31:0] crc;
		bit crc_bad;
		frame_bytes.delete();
		repeat (frame_span() - CRC_BYTES) begin
			frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
		end
		if (flaw != FLAW_NOISE) begin
			frame_bytes[0] = magic_q[7:0];
			frame_bytes[1] = magic_q[15:8];
			frame_bytes[2] = version_q;
			frame_bytes[4] = seq[7:0];
			frame_bytes[5] = seq[15:8];
			frame_bytes[10] = length_q[7:0];
			frame_bytes[11] = length_q[15:8];
			frame_bytes[12] = 8'd0;
			frame_bytes[13] = 8'd0;
		end
		crc_bad = (flaw == FLAW_CRC);
		if (flaw == FLAW_MANY) begin
			repeat ($urandom_range(2, 4)) begin
				spoil_header(flaw_e'($urandom_range(FLAW_MAGIC, FLAW_LEN_HIGH)));
			end
			crc_bad = 1'($urandom_range(0, 1));
		end else begin
			spoil_header(flaw);
		end
		crc = CRC_INIT;
		foreach (frame_bytes[i]) begin
			crc = crc_step(crc, frame_bytes[i]);
		end
		crc = ~crc;
		if (crc_bad) begin
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		end
		if (flaw == FLAW_NOISE) begin
			crc = $urandom;
		end
		for (int i = 0; i < CRC_BYTES; i++) begin
			frame_bytes.push_back(crc[8 * i +: 8]);
		end
	endtask

	task automatic send_frame(input logic [15:0] seq, input flaw_e flaw, input int fill);
		byte_word_t w;
		build_frame(seq, flaw, fill);
		foreach (frame_bytes[i]) begin
			w.data_byte = frame_bytes[i];
			w.expected_seq = (i == 0) ? seq : 16'($urandom);
			send_byte(w);
		end
	endtask

	task automatic test_reset_defaults();
		send_frame(16'h0000, FLAW_NONE, -1);
		send_frame(16'hFFFF, FLAW_CRC, -1);
		settle();
	endtask

	task automatic test_byte_extremes();
		write_reg(CFG_LENGTH, 32'd24);
		send_frame(16'h0000, FLAW_NONE, 0);
		send_frame(16'hFFFF, FLAW_NONE, 255);
		send_frame(16'hFFFF, FLAW_NONE, 0);
		send_frame(16'h0000, FLAW_NONE, 255);
		settle();
	endtask

	task automatic test_each_error();
		for (int f = FLAW_MAGIC; f <= FLAW_CRC; f++) begin
			send_frame(16'($urandom), flaw_e'(f), -1);
		end
		repeat (4) send_frame(16'($urandom), FLAW_MANY, -1);
		settle();
	endtask

	task automatic test_short_length();
		write_reg(CFG_LENGTH, 32'd0);
		send_frame(16'($urandom), FLAW_NONE, -1);
		send_frame(16'($urandom), FLAW_LEN_LOW, -1);
		settle();
		write_reg(CFG_LENGTH, 32'd19);
		send_frame(16'($urandom), FLAW_NONE, -1);
		settle();
		write_reg(CFG_LENGTH, 32'd20);
		send_frame(16'($urandom), FLAW_NONE, -1);
		send_frame(16'($urandom), FLAW_LEN_HIGH, -1);
		settle();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_POLY, 32'h0000_0000);
		send_frame(16'($urandom), FLAW_NONE, -1);
		settle();
		write_reg(CFG_POLY, 32'hFFFF_FFFF);
		write_reg(CFG_MAGIC, 32'h0000);
		write_reg(CFG_VERSION, 32'h00);
		send_frame(16'($urandom), FLAW_NONE, -1);
		settle();
		write_reg(CFG_MAGIC, 32'hFFFF);
		write_reg(CFG_VERSION, 32'hFF);
		send_frame(16'($urandom), FLAW_NONE, -1);
		send_frame(16'($urandom), FLAW_MAGIC, -1);
		settle();
		write_reg(CFG_POLY, POLY_RESET);
	endtask

	task automatic pick_setting();
		int which;
		int r;
		which = $urandom_range(1, 15);
		if (which[0]) begin
			write_reg(CFG_POLY, ($urandom_range(0, 1) != 0) ? POLY_RESET : 32'($urandom));
		end
		if (which[1]) begin
			r = $urandom_range(0, 9);
			write_reg(CFG_MAGIC, (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
		end
		if (which[2]) begin
			write_reg(CFG_VERSION, 32'($urandom_range(0, 255)));
		end
		if (which[3]) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				write_reg(CFG_LENGTH, 32'($urandom_range(0, 19)));
			end else if (r < 98) begin
				write_reg(CFG_LENGTH, 32'($urandom_range(20, 48)));
			end else begin
				write_reg(CFG_LENGTH, 32'd404);
			end
		end
	endtask

	task automatic test_random_traffic();
		int start;
		int frames_left;
		int r;
		flaw_e flaw;
		start = words_sent;
		frames_left = 0;
		while (words_sent - start < RANDOM_BYTES) begin
			if (frames_left == 0) begin
				settle();
				pick_setting();
				frames_left = $urandom_range(2, 8);
			end
			calm = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 65) begin
				flaw = FLAW_NONE;
			end else if (r < 93) begin
				flaw = flaw_e'($urandom_range(FLAW_MAGIC, FLAW_MANY));
			end else begin
				flaw = FLAW_NOISE;
			end
			send_frame(16'($urandom), flaw, -1);
			frames_left--;
		end
		calm = 1'b0;
		settle();
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_byte_extremes();
		test_each_error();
		test_short_length();
		test_register_extremes();
		test_random_traffic();
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fhcc_pkg.sv
rtl/fhcc_cfg.sv
rtl/fhcc_crc8.sv
rtl/fhcc_track.sv
rtl/fhcc_out.sv
rtl/frame_header_crc_checker.sv
rtl/fhcc_checker.sv
tb/tb.sv
